// ===== hw/rtl/icmp_echo_responder_defines.svh =====
// assertion macros for the checker file
`ifndef ICMP_ECHO_RESPONDER_DEFINES_SVH
`define ICMP_ECHO_RESPONDER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define IER_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define IER_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ier_pkg.sv =====
`timescale 1ns / 1ps

package ier_pkg;

  localparam int HdrLen   = 42;
  localparam int IpEnd    = 34;
  localparam int PosW     = 6;
  localparam int CountW   = 64;
  localparam int KeyW     = 32;

  localparam logic [7:0]  EtherTypeHi = 8'h08;
  localparam logic [7:0]  EtherTypeLo = 8'h00;
  localparam logic [7:0]  ProtoIcmp   = 8'd1;
  localparam logic [7:0]  TypeEchoReq = 8'd8;
  localparam logic [7:0]  TypeEchoRep = 8'd0;
  // ones-complement of the type/code word change 0x0800 -> 0x0000
  localparam logic [15:0] ChkAdj      = 16'hF7FF;

  typedef struct packed {
    logic [7:0]        data;
    logic              last;
    logic              verdict;
    logic [CountW-1:0] count;
  } item_t;

  typedef struct packed {
    logic            valid;
    logic [KeyW-1:0] key;
  } lkup_req_t;

  typedef struct packed {
    logic              done;
    logic [CountW-1:0] count;
  } lkup_rsp_t;

  typedef enum logic [1:0] {
    F_COLLECT,
    F_WAIT,
    F_EMIT,
    F_PASS
  } front_state_t;

  typedef enum logic [1:0] {
    T_IDLE,
    T_READ,
    T_CMP,
    T_CNT
  } tbl_state_t;

  typedef enum logic [0:0] {
    T_HIT,
    T_NEW
  } tbl_kind_t;

endpackage

// ===== hw/rtl/icmp_echo_responder.sv =====
`timescale 1ns / 1ps
// channel   ports                                          role
// in        in_valid in_ready in_frame_byte in_frame_last  received frame, one byte per item
// out       out_valid out_ready out_byte out_last          rewritten frame, one byte per item
//           out_verdict out_source_count                   per-frame verdict and source ICMP frame count
//
// header bytes 1..42 are taken one per cycle; the source lookup starts at byte 34 and
// scans the key memory one stored key at a time, read then compare, so bytes 35..42 overlap it.
// the held header then drains at one byte per cycle while the queue has room and input
// waits; later bytes pass at one per cycle, while the queue has room, through a 4-entry queue.
// reset empties the table at once through its fill count; no clearing pass.
// either side may stall at any time; the queue parts input from output.

module icmp_echo_responder #(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_frame_byte,
  input  logic        in_frame_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic        out_verdict,
  output logic [63:0] out_source_count
);

  ier_pkg::lkup_req_t req;
  ier_pkg::lkup_rsp_t rsp;
  ier_pkg::item_t     push_item;
  ier_pkg::item_t     head;
  logic               push;
  logic               fifo_full;

  ier_table #(
    .Entries(TABLE_ENTRIES)
  ) u_table (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (req),
    .rsp  (rsp)
  );

  ier_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_frame_byte),
    .in_last  (in_frame_last),
    .push     (push),
    .push_item(push_item),
    .fifo_full(fifo_full),
    .req      (req),
    .rsp      (rsp)
  );

  ier_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_item(push_item),
    .full     (fifo_full),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .head     (head)
  );

  assign out_byte         = head.data;
  assign out_last         = head.last;
  assign out_verdict      = head.verdict;
  assign out_source_count = head.count;

endmodule

// ===== hw/rtl/ier_table.sv =====
`timescale 1ns / 1ps

module ier_table #(
  parameter int Entries = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ier_pkg::lkup_req_t req,
  output ier_pkg::lkup_rsp_t rsp
);

  localparam int IW = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int CW = $clog2(Entries + 1);

  logic [ier_pkg::KeyW-1:0]   key_mem [Entries];
  logic [ier_pkg::CountW-1:0] cnt_mem [Entries];

  ier_pkg::tbl_state_t        state_r, state_nxt;
  logic [CW-1:0]              idx_r, idx_nxt;
  logic [CW-1:0]              fill_r, fill_nxt;
  logic [ier_pkg::KeyW-1:0]   key_r, key_nxt;
  logic [ier_pkg::KeyW-1:0]   kd_r;
  logic [ier_pkg::CountW-1:0] cd_r;
  logic                       done_r, done_nxt;
  logic [ier_pkg::CountW-1:0] res_r, res_nxt;

  logic                       key_rd, cnt_rd, new_we, cnt_we;
  logic [ier_pkg::CountW-1:0] cnt_wd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ier_pkg::T_IDLE;
      idx_r   <= '0;
      fill_r  <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      fill_r  <= fill_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    res_r <= res_nxt;
  end

  // key and count memories, registered reads
  always_ff @(posedge clk) begin
    if (key_rd) begin
      kd_r <= key_mem[idx_r[IW-1:0]];
    end
    if (cnt_rd) begin
      cd_r <= cnt_mem[idx_r[IW-1:0]];
    end
    if (new_we) begin
      key_mem[fill_r[IW-1:0]] <= key_r;
      cnt_mem[fill_r[IW-1:0]] <= {{(ier_pkg::CountW-1){1'b0}}, 1'b1};
    end else if (cnt_we) begin
      cnt_mem[idx_r[IW-1:0]] <= cnt_wd;
    end
  end

  // valid entries always form a prefix, so the fill count stands in for valid marks
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    fill_nxt  = fill_r;
    key_nxt   = key_r;
    done_nxt  = 1'b0;
    res_nxt   = res_r;
    key_rd    = 1'b0;
    cnt_rd    = 1'b0;
    new_we    = 1'b0;
    cnt_we    = 1'b0;
    cnt_wd    = cd_r + {{(ier_pkg::CountW-1){1'b0}}, 1'b1};
    case (state_r)
      ier_pkg::T_IDLE: begin
        if (req.valid) begin
          key_nxt   = req.key;
          idx_nxt   = '0;
          state_nxt = ier_pkg::T_READ;
        end
      end
      ier_pkg::T_READ: begin
        if (idx_r == fill_r) begin
          // no match: take the next free entry if any
          if (fill_r != CW'(Entries)) begin
            new_we   = 1'b1;
            fill_nxt = fill_r + 1'b1;
          end
          res_nxt   = {{(ier_pkg::CountW-1){1'b0}}, 1'b1};
          done_nxt  = 1'b1;
          state_nxt = ier_pkg::T_IDLE;
        end else begin
          key_rd    = 1'b1;
          state_nxt = ier_pkg::T_CMP;
        end
      end
      ier_pkg::T_CMP: begin
        if (kd_r == key_r) begin
          cnt_rd    = 1'b1;
          state_nxt = ier_pkg::T_CNT;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ier_pkg::T_READ;
        end
      end
      ier_pkg::T_CNT: begin
        cnt_we    = 1'b1;
        res_nxt   = cnt_wd;
        done_nxt  = 1'b1;
        state_nxt = ier_pkg::T_IDLE;
      end
      default: state_nxt = ier_pkg::T_IDLE;
    endcase
  end

  assign rsp.done  = done_r;
  assign rsp.count = res_r;

endmodule

// ===== hw/rtl/ier_fifo.sv =====
`timescale 1ns / 1ps

module ier_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ier_pkg::item_t push_item,
  output logic           full,
  output logic           out_valid,
  input  logic           out_ready,
  output ier_pkg::item_t head
);

  localparam int Depth = 4;
  localparam int AW    = $clog2(Depth);

  ier_pkg::item_t mem_r [Depth];
  logic [AW-1:0]  wp_r, wp_nxt;
  logic [AW-1:0]  rp_r, rp_nxt;
  logic [AW:0]    cnt_r, cnt_nxt;
  logic           pop;

  assign full      = (cnt_r == (AW+1)'(Depth));
  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;
  assign head      = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (AW+1)'(push) - (AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
  end

endmodule

// ===== hw/rtl/ier_front.sv =====
`timescale 1ns / 1ps

module ier_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_byte,
  input  logic               in_last,
  output logic               push,
  output ier_pkg::item_t     push_item,
  input  logic               fifo_full,
  output ier_pkg::lkup_req_t req,
  input  ier_pkg::lkup_rsp_t rsp
);

  localparam int HL = ier_pkg::HdrLen;
  localparam int PW = ier_pkg::PosW;

  ier_pkg::front_state_t      state_r, state_nxt;
  logic [PW-1:0]              pos_r, pos_nxt;
  logic [PW-1:0]              left_r, left_nxt;
  logic                       last_seen_r, last_seen_nxt;
  logic                       pending_r, pending_nxt;
  logic                       reply_r, reply_nxt;
  logic [ier_pkg::CountW-1:0] count_r, count_nxt;
  logic [7:0]                 hdr_r [HL];
  logic [7:0]                 rw [HL];

  logic        hdr_we, shift, rewrite;
  logic [16:0] sum0;
  logic [16:0] sum1;
  logic [15:0] csum;

  // incremental checksum update, end-around carry
  always_comb begin
    sum0 = {1'b0, ~{hdr_r[36], hdr_r[37]}} + {1'b0, ier_pkg::ChkAdj};
    sum1 = {1'b0, sum0[15:0]} + {16'd0, sum0[16]};
    csum = ~(sum1[15:0] + {15'd0, sum1[16]});
  end

  // echo reply header: swap macs and ips, type to reply, updated checksum
  always_comb begin
    for (int i = 0; i < HL; i++) begin
      rw[i] = hdr_r[i];
    end
    for (int i = 0; i < 6; i++) begin
      rw[i]     = hdr_r[i + 6];
      rw[i + 6] = hdr_r[i];
    end
    for (int i = 0; i < 4; i++) begin
      rw[26 + i] = hdr_r[30 + i];
      rw[30 + i] = hdr_r[26 + i];
    end
    rw[34] = ier_pkg::TypeEchoRep;
    rw[36] = csum[15:8];
    rw[37] = csum[7:0];
  end

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    left_nxt      = left_r;
    last_seen_nxt = last_seen_r;
    pending_nxt   = pending_r;
    reply_nxt     = reply_r;
    count_nxt     = count_r;
    in_ready      = 1'b0;
    push          = 1'b0;
    push_item     = '{data: hdr_r[0], last: last_seen_r && (left_r == PW'(1)),
                      verdict: reply_r, count: count_r};
    req.valid     = 1'b0;
    req.key       = {hdr_r[26], hdr_r[27], hdr_r[28], hdr_r[29]};
    hdr_we        = 1'b0;
    shift         = 1'b0;
    rewrite       = 1'b0;

    if (rsp.done) begin
      pending_nxt = 1'b0;
      count_nxt   = rsp.count;
    end

    case (state_r)
      ier_pkg::F_COLLECT: begin
        in_ready = 1'b1;
        if (in_valid) begin
          hdr_we  = 1'b1;
          pos_nxt = pos_r + 1'b1;
          // the byte completing the ip header arrives now
          if (pos_r == PW'(ier_pkg::IpEnd - 1) && hdr_r[12] == ier_pkg::EtherTypeHi &&
              hdr_r[13] == ier_pkg::EtherTypeLo && hdr_r[23] == ier_pkg::ProtoIcmp) begin
            req.valid   = 1'b1;
            pending_nxt = 1'b1;
          end
          if (in_last || pos_r == PW'(HL - 1)) begin
            last_seen_nxt = in_last;
            state_nxt     = ier_pkg::F_WAIT;
          end
        end
      end
      ier_pkg::F_WAIT: begin
        if (!pending_r) begin
          rewrite   = (pos_r == PW'(HL)) && (count_r != '0) &&
                      (hdr_r[34] == ier_pkg::TypeEchoReq);
          reply_nxt = rewrite;
          left_nxt  = pos_r;
          state_nxt = ier_pkg::F_EMIT;
        end
      end
      ier_pkg::F_EMIT: begin
        if (!fifo_full) begin
          push     = 1'b1;
          shift    = 1'b1;
          left_nxt = left_r - 1'b1;
          if (left_r == PW'(1)) begin
            if (last_seen_r) begin
              pos_nxt       = '0;
              reply_nxt     = 1'b0;
              count_nxt     = '0;
              last_seen_nxt = 1'b0;
              state_nxt     = ier_pkg::F_COLLECT;
            end else begin
              state_nxt = ier_pkg::F_PASS;
            end
          end
        end
      end
      ier_pkg::F_PASS: begin
        in_ready  = !fifo_full;
        push      = in_valid && !fifo_full;
        push_item = '{data: in_byte, last: in_last, verdict: reply_r, count: count_r};
        if (push && in_last) begin
          pos_nxt       = '0;
          reply_nxt     = 1'b0;
          count_nxt     = '0;
          last_seen_nxt = 1'b0;
          state_nxt     = ier_pkg::F_COLLECT;
        end
      end
      default: state_nxt = ier_pkg::F_COLLECT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ier_pkg::F_COLLECT;
      pos_r       <= '0;
      left_r      <= '0;
      last_seen_r <= 1'b0;
      pending_r   <= 1'b0;
      reply_r     <= 1'b0;
      count_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      left_r      <= left_nxt;
      last_seen_r <= last_seen_nxt;
      pending_r   <= pending_nxt;
      reply_r     <= reply_nxt;
      count_r     <= count_nxt;
    end
  end

  // header line: written by position, loaded with the reply rewrite, shifted toward entry 0 while emitting
  always_ff @(posedge clk) begin
    for (int i = 0; i < HL; i++) begin
      if (rewrite) begin
        hdr_r[i] <= rw[i];
      end else if (shift) begin
        if (i < HL - 1) begin
          hdr_r[i] <= hdr_r[(i < HL - 1) ? i + 1 : i];
        end
      end else if (hdr_we && pos_r == PW'(i)) begin
        hdr_r[i] <= in_byte;
      end
    end
  end

endmodule

// ===== hw/rtl/ier_checker.sv =====
`timescale 1ns / 1ps
`include "icmp_echo_responder_defines.svh"

module ier_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic        out_last,
  input logic        out_verdict,
  input logic [63:0] out_source_count
);

  `IER_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_last), "stalled out item changed")
  // a reply is only sent for a counted source
  `IER_ASSERT_SAME(a_reply_counted, out_valid && out_verdict, out_source_count != 64'd0, "reply with zero count")
  // verdict and count stay fixed inside one frame
  `IER_ASSERT_NEXT(a_frame_const, out_valid && out_ready && !out_last, !out_valid || (out_source_count == $past(out_source_count) && out_verdict == $past(out_verdict)), "frame fields changed mid frame")

endmodule

bind icmp_echo_responder ier_checker u_ier_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_byte        (out_byte),
  .out_last        (out_last),
  .out_verdict     (out_verdict),
  .out_source_count(out_source_count)
);
